### hdl/u8g_pkg.sv
// ----------------------------------------------------------------------------
// u8g_pkg
// Shared types, constants and the Cyrillic look-alike table of the UTF-8
// to glyph code converter.
// ----------------------------------------------------------------------------
package u8g_pkg;

    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;
    localparam int GLYPH_W = 7;
    localparam int ADV_W   = 7;
    localparam int TOTAL_W = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ADV_W-1:0]   WIDTH_RESET = 7'd8;
    localparam logic [ADV_W-1:0]   BOX_ADVANCE = 7'd16;
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;
    localparam logic [GLYPH_W-1:0] GLYPH_QMARK = 7'h3F;
    localparam logic [GLYPH_W-1:0] GLYPH_NONE  = 7'd0;

    // Box glyph ranges
    localparam logic [CP_W-1:0] CJK_LO     = 21'h004E00;
    localparam logic [CP_W-1:0] CJK_HI     = 21'h009FFF;
    localparam logic [CP_W-1:0] CJK_EXT_LO = 21'h003400;
    localparam logic [CP_W-1:0] CJK_EXT_HI = 21'h004DBF;
    localparam logic [CP_W-1:0] CJK_CMP_LO = 21'h00F900;
    localparam logic [CP_W-1:0] CJK_CMP_HI = 21'h00FAFF;
    localparam logic [CP_W-1:0] CJK_SYM_LO = 21'h003000;
    localparam logic [CP_W-1:0] CJK_SYM_HI = 21'h0030FF;
    localparam logic [CP_W-1:0] CJK_FW_LO  = 21'h00FF00;
    localparam logic [CP_W-1:0] CJK_FW_HI  = 21'h00FFEF;

    // Cyrillic block and its basic letters
    localparam logic [CP_W-1:0] CYR_LO        = 21'h000400;
    localparam logic [CP_W-1:0] CYR_HI        = 21'h0004FF;
    localparam logic [CP_W-1:0] CYR_LETTER_LO = 21'h000410;
    localparam logic [CP_W-1:0] CYR_LETTER_HI = 21'h00044F;

    localparam logic [CP_W-1:0] PRINT_LO = 21'd32;
    localparam logic [CP_W-1:0] PRINT_HI = 21'd127;

    // First character sits in the top byte
    localparam logic [8*64-1:0] CYR_STR =
        "ABBTDEX3NNKNMHONPCTYOXU4WWbbb3ORabbrdex3nnknmnonpctyoxu4wwbbb3or";

    // Request from the decoder to the glyph mapper
    typedef struct packed {
        logic            clear;
        logic [CP_W-1:0] cp;
    } cp_req_t;

    // Finished result
    typedef struct packed {
        logic [CP_W-1:0]    codepoint;
        logic               is_box;
        logic [GLYPH_W-1:0] glyph_code;
        logic [ADV_W-1:0]   advance;
        logic [TOTAL_W-1:0] total_width;
    } glyph_req_t;

    function automatic logic [GLYPH_W-1:0] cyr_glyph(input logic [5:0] idx);
        logic [8:0] pos;
        pos = {~idx, 3'b000};
        return CYR_STR[pos +: GLYPH_W];
    endfunction

endpackage

### hdl/u8g_fifo.sv
// ----------------------------------------------------------------------------
// u8g_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module u8g_fifo
    import u8g_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !(pop && !empty)) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

### hdl/u8g_decode.sv
// ----------------------------------------------------------------------------
// u8g_decode
// Front end: take one byte a cycle while q_full is low, rebuild codepoints, queue nonzero ones.
// ----------------------------------------------------------------------------
module u8g_decode
    import u8g_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              string_start,
    input  logic              q_full,
    output logic              q_push,
    output cp_req_t           q_item
);

    logic [1:0]      pend_reg, pend_next;
    logic [CP_W-1:0] acc_reg, acc_next;
    logic            clear_pend_reg, clear_pend_next;

    logic            accept;
    logic [1:0]      pend;
    logic [CP_W-1:0] acc;
    logic [CP_W-1:0] cont;
    logic [CP_W-1:0] acc_merged;
    logic            clr;
    logic            emit;
    logic [CP_W-1:0] cp;

    assign accept = push && !q_full;

    always_comb
    begin
        pend = string_start ? 2'd0 : pend_reg;
        acc  = string_start ? '0 : acc_reg;
        clr  = string_start || clear_pend_reg;

        case (pend)
            2'd1:    cont = {15'd0, text_byte[5:0]};
            2'd2:    cont = {9'd0, text_byte[5:0], 6'd0};
            default: cont = {3'd0, text_byte[5:0], 12'd0};
        endcase
        if (text_byte[7:6] == 2'b00)
        begin
            cont = '0;
        end
        acc_merged = acc | cont;

        pend_next       = pend_reg;
        acc_next        = acc_reg;
        clear_pend_next = clear_pend_reg;
        emit            = 1'b0;
        cp              = '0;
        q_push          = 1'b0;

        if (accept)
        begin
            pend_next       = pend;
            acc_next        = acc;
            clear_pend_next = clr;
            if (pend != 2'd0)
            begin
                pend_next = pend - 2'd1;
                if (pend == 2'd1)
                begin
                    cp       = acc_merged;
                    emit     = 1'b1;
                    acc_next = '0;
                end
                else
                begin
                    acc_next = acc_merged;
                end
            end
            else if (text_byte inside {[8'h00:8'h7F]})
            begin
                cp   = {13'd0, text_byte};
                emit = 1'b1;
            end
            else if (text_byte inside {[8'hC0:8'hDF]})
            begin
                acc_next  = {10'd0, text_byte[4:0], 6'd0};
                pend_next = 2'd1;
            end
            else if (text_byte inside {[8'hE0:8'hEF]})
            begin
                acc_next  = {5'd0, text_byte[3:0], 12'd0};
                pend_next = 2'd2;
            end
            else if (text_byte inside {[8'hF0:8'hF7]})
            begin
                acc_next  = {text_byte[2:0], 18'd0};
                pend_next = 2'd3;
            end
            else
            begin
                // stray continuation or bad lead stands alone
                cp   = {13'd0, text_byte};
                emit = 1'b1;
            end

            if (emit && (cp != '0))
            begin
                q_push          = 1'b1;
                clear_pend_next = 1'b0;
            end
        end
    end

    assign q_item.clear = clr;
    assign q_item.cp    = cp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            acc_reg        <= '0;
            clear_pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg       <= pend_next;
            acc_reg        <= acc_next;
            clear_pend_reg <= clear_pend_next;
        end
    end

    a_clear_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && string_start && !q_push) |=> clear_pend_reg)
        else $error("string start lost before next request");

endmodule

### hdl/u8g_map.sv
// ----------------------------------------------------------------------------
// u8g_map
// Back end: choose the glyph, advance and saturating running width.
// ----------------------------------------------------------------------------
module u8g_map
    import u8g_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ADV_W-1:0] glyph_width,
    input  logic             in_valid,
    input  cp_req_t          in_item,
    output logic             in_pop,
    input  logic             out_full,
    output logic             out_push,
    output glyph_req_t       out_item
);

    logic [TOTAL_W-1:0] rw_reg, rw_next;
    logic [CP_W-1:0]    cp;
    logic               box;
    logic               cyr_block;
    logic               cyr_letter;
    logic [5:0]         cyr_idx;
    logic [GLYPH_W-1:0] glyph;
    logic [ADV_W-1:0]   adv;
    logic [TOTAL_W-1:0] base;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] total;

    assign in_pop   = in_valid && !out_full;
    assign out_push = in_pop;
    assign cp       = in_item.cp;

    always_comb
    begin
        box = ((cp >= CJK_LO)     && (cp <= CJK_HI))     ||
              ((cp >= CJK_EXT_LO) && (cp <= CJK_EXT_HI)) ||
              ((cp >= CJK_CMP_LO) && (cp <= CJK_CMP_HI)) ||
              ((cp >= CJK_SYM_LO) && (cp <= CJK_SYM_HI)) ||
              ((cp >= CJK_FW_LO)  && (cp <= CJK_FW_HI));
        cyr_block  = (cp >= CYR_LO) && (cp <= CYR_HI);
        cyr_letter = (cp >= CYR_LETTER_LO) && (cp <= CYR_LETTER_HI);
        cyr_idx    = cp[5:0] - 6'h10;

        if (box)
        begin
            glyph = GLYPH_NONE;
        end
        else if (cyr_block)
        begin
            glyph = cyr_letter ? cyr_glyph(cyr_idx) : GLYPH_QMARK;
        end
        else if ((cp < PRINT_LO) || (cp > PRINT_HI))
        begin
            glyph = GLYPH_SPACE;
        end
        else
        begin
            glyph = cp[GLYPH_W-1:0];
        end

        adv   = box ? BOX_ADVANCE : glyph_width;
        base  = in_item.clear ? '0 : rw_reg;
        sum   = {1'b0, base} + {{(TOTAL_W + 1 - ADV_W){1'b0}}, adv};
        total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

        rw_next = in_pop ? total : rw_reg;
    end

    assign out_item.codepoint   = cp;
    assign out_item.is_box      = box;
    assign out_item.glyph_code  = glyph;
    assign out_item.advance     = adv;
    assign out_item.total_width = total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg <= '0;
        end
        else
        begin
            rw_reg <= rw_next;
        end
    end

    a_width_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        in_pop |=> rw_reg == $past(out_item.total_width))
        else $error("running width does not follow the emitted total");

    a_width_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (in_pop && !in_item.clear) |-> out_item.total_width >= rw_reg)
        else $error("running width went down without a string start");

endmodule

### hdl/utf8_text_to_glyph_codes.sv
// ----------------------------------------------------------------------------
// utf8_text_to_glyph_codes
// UTF-8 byte stream to built-in bitmap glyph codes with running width.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per clock (push while full is low) and
// sends out one result per nonzero codepoint on a queue-style port (read
// while empty is low, pop to advance). A byte is decoded in the cycle it is
// taken, and a finished codepoint is written into a short request queue at
// that same edge. The glyph mapper takes it from the head of that queue,
// when the output queue has room, and writes the result into the output
// queue, whose head drives the output. Sustained rate is one byte per
// clock, limited by the single decode step per byte. full rises only when
// the output side pops slower than results arrive and both queues have
// filled (DEPTH requests each). string_start clears the decoder and the
// running width before its own byte. glyph_width is written through the
// cfg_valid/cfg_ready channel (always ready) and should only change while
// no text is in flight. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module utf8_text_to_glyph_codes
    import u8g_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,

    // Byte input
    input  logic               push,
    output logic               full,
    input  logic [BYTE_W-1:0]  text_byte,
    input  logic               string_start,

    // Result output
    output logic               empty,
    input  logic               pop,
    output logic [CP_W-1:0]    codepoint,
    output logic               is_box,
    output logic [GLYPH_W-1:0] glyph_code,
    output logic [ADV_W-1:0]   advance,
    output logic [TOTAL_W-1:0] total_width,

    // Width register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ADV_W-1:0]   glyph_width
);

    logic [ADV_W-1:0] glyph_width_reg;

    // Decoder to mid queue
    logic       dec_push;
    cp_req_t    dec_item;
    logic       mid_full;
    logic       mid_empty;
    cp_req_t    mid_item;
    logic       mid_pop;

    // Mapper to output queue
    logic       map_push;
    glyph_req_t map_item;
    logic       out_full;
    glyph_req_t out_item;

    // Width register: always ready, hold last value written
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            glyph_width_reg <= glyph_width;
        end
    end

    // Front end: accept bytes whenever the request queue has room
    assign full = mid_full;

    u8g_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .text_byte    (text_byte),
        .string_start (string_start),
        .q_full       (mid_full),
        .q_push       (dec_push),
        .q_item       (dec_item)
    );

    u8g_fifo #(
        .WIDTH ($bits(cp_req_t)),
        .DEPTH (DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (dec_push),
        .wr_data (dec_item),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_item),
        .empty   (mid_empty)
    );

    // Back end: map one request per cycle while the output queue has room
    u8g_map u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .glyph_width (glyph_width_reg),
        .in_valid    (!mid_empty),
        .in_item     (mid_item),
        .in_pop      (mid_pop),
        .out_full    (out_full),
        .out_push    (map_push),
        .out_item    (map_item)
    );

    u8g_fifo #(
        .WIDTH ($bits(glyph_req_t)),
        .DEPTH (DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (map_push),
        .wr_data (map_item),
        .full    (out_full),
        .pop     (pop),
        .rd_data (out_item),
        .empty   (empty)
    );

    assign codepoint   = out_item.codepoint;
    assign is_box      = out_item.is_box;
    assign glyph_code  = out_item.glyph_code;
    assign advance     = out_item.advance;
    assign total_width = out_item.total_width;

    // The request queue only fills while the mapper was held by a full
    // output queue in the cycle before
    a_full_means_stall: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> $past(out_full))
        else $error("input stalled although the output queue had room");

endmodule
